// ----- rtl/cfu_pkg.sv -----
// Shared constants and types for the correlation filter update block.
`timescale 1ns / 1ps
package cfu_pkg;

	// Number of per-bin entries; a power of two, so the bin index wraps by masking
	localparam int NUM_BINS = 4096;
	localparam int ADDR_W   = $clog2(NUM_BINS);

	// Transaction field widths
	localparam int IDX_W  = 12;
	localparam int F_W    = 24;
	localparam int G_W    = 18;
	localparam int H_W    = 32;
	localparam int RATE_W = 17;

	// Internal number formats: numerator Q.16 below 2^42, energy below 2^48
	localparam int NUM_W = 43;
	localparam int EN_W  = 48;
	localparam int FRAC  = 16;
	localparam int HSH   = 14;
	localparam int MAG_W = NUM_W - 1 + HSH;
	localparam int Q_W   = H_W;

	// Writes still in flight between the memory read and write ports
	localparam int FWD_DEPTH = 5;

	localparam logic [RATE_W-1:0] ONE_Q16 = RATE_W'(65536);
	localparam logic [RATE_W-1:0] RATE_RST = RATE_W'(8192);

	localparam logic signed [H_W-1:0] H_MAX = {1'b0, {(H_W-1){1'b1}}};
	localparam logic signed [H_W-1:0] H_MIN = {1'b1, {(H_W-1){1'b0}}};

	// Register map: data 32 bits, registers on 4-byte steps
	localparam int PADDR_W = 3;
	localparam logic REG_ACCUM = 1'b0;
	localparam logic REG_RATE  = 1'b1;

	typedef struct packed {
		logic signed [NUM_W-1:0] nre;
		logic signed [NUM_W-1:0] nim;
		logic [EN_W-1:0]         energy;
	} cfu_entry_t;

endpackage

// ----- rtl/cfu_bin_if.sv -----
// Input channel: one frequency bin per transaction.
`timescale 1ns / 1ps
interface cfu_bin_if;
	import cfu_pkg::*;

	logic                    valid;
	logic                    ready;
	logic [IDX_W-1:0]        bin_index;
	logic signed [F_W-1:0]   f_real;
	logic signed [F_W-1:0]   f_imag;
	logic signed [G_W-1:0]   g_real;
	logic signed [G_W-1:0]   g_imag;

	modport source (output valid, bin_index, f_real, f_imag, g_real, g_imag, input ready);
	modport sink (input valid, bin_index, f_real, f_imag, g_real, g_imag, output ready);
endinterface

// ----- rtl/cfu_filt_if.sv -----
// Output channel: one filter bin per transaction.
`timescale 1ns / 1ps
interface cfu_filt_if;
	import cfu_pkg::*;

	logic                  valid;
	logic                  ready;
	logic signed [H_W-1:0] h_real;
	logic signed [H_W-1:0] h_imag;
	logic                  zero_energy;

	modport source (output valid, h_real, h_imag, zero_energy, input ready);
	modport sink (input valid, h_real, h_imag, zero_energy, output ready);
endinterface

// ----- rtl/cfu_div.sv -----
// Pipelined restoring divider: two saturated quotients A*2^14/B, one bit per stage.
`timescale 1ns / 1ps
module cfu_div (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              en,
	input  logic                              in_valid,
	input  logic signed [cfu_pkg::NUM_W-1:0]  num_re,
	input  logic signed [cfu_pkg::NUM_W-1:0]  num_im,
	input  logic [cfu_pkg::EN_W-1:0]          den,
	output logic                              out_valid,
	output logic signed [cfu_pkg::H_W-1:0]    h_re,
	output logic signed [cfu_pkg::H_W-1:0]    h_im,
	output logic                              zero
);
	import cfu_pkg::*;

	localparam int DW    = EN_W + Q_W;
	localparam int OVF_W = EN_W + Q_W - HSH;

	typedef struct packed {
		logic             neg;
		logic             nz;
		logic             ovf;
		logic [MAG_W-1:0] rem;
		logic [Q_W-1:0]   q;
	} lane_t;

	logic            v_q    [0:Q_W];
	logic            zero_q [0:Q_W];
	logic [EN_W-1:0] den_q  [0:Q_W];
	lane_t           re_q   [0:Q_W];
	lane_t           im_q   [0:Q_W];

	// Set up one lane: magnitude, sign and quotient overflow (q >= 2^32)
	function automatic lane_t lane_load(input logic signed [NUM_W-1:0] a,
			input logic [EN_W-1:0] d);
		logic [NUM_W-1:0] absv;
		lane_t            l;
		absv  = a[NUM_W-1] ? NUM_W'(-a) : NUM_W'(a);
		l.neg = a[NUM_W-1];
		l.nz  = (a != '0);
		l.ovf = (OVF_W'(absv) >= {d, {(Q_W-HSH){1'b0}}});
		l.rem = {absv[NUM_W-2:0], {HSH{1'b0}}};
		l.q   = '0;
		return l;
	endfunction

	// One restoring step for quotient bit j
	function automatic lane_t div_step(input lane_t l, input logic [EN_W-1:0] d, input int j);
		logic [DW-1:0] dsh;
		logic [DW-1:0] rext;
		logic          take;
		lane_t         o;
		dsh   = DW'(d) << j;
		rext  = DW'(l.rem);
		take  = (rext >= dsh);
		o     = l;
		o.rem = take ? MAG_W'(rext - dsh) : l.rem;
		o.q   = {l.q[Q_W-2:0], take};
		return o;
	endfunction

	// Saturate a finished lane to the signed output range
	function automatic logic signed [H_W-1:0] lane_sat(input lane_t l, input logic z);
		logic signed [H_W-1:0] r;
		if (z) begin
			r = l.neg ? H_MIN : (l.nz ? H_MAX : '0);
		end else if (l.ovf) begin
			r = l.neg ? H_MIN : H_MAX;
		end else if (l.neg) begin
			r = (l.q > {1'b1, {(Q_W-1){1'b0}}}) ? H_MIN : H_W'(-l.q);
		end else begin
			r = l.q[Q_W-1] ? H_MAX : H_W'(l.q);
		end
		return r;
	endfunction

	// Entry stage valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q[0] <= 1'b0;
		end else if (en) begin
			v_q[0] <= in_valid;
		end
	end

	// Entry stage payload
	always_ff @(posedge clk) begin
		if (en) begin
			zero_q[0] <= (den == '0);
			den_q[0]  <= den;
			re_q[0]   <= lane_load(num_re, den);
			im_q[0]   <= lane_load(num_im, den);
		end
	end

	// One quotient bit per stage, most significant first
	for (genvar k = 0; k < Q_W; k++) begin : g_stage
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_q[k+1] <= 1'b0;
			end else if (en) begin
				v_q[k+1] <= v_q[k];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				zero_q[k+1] <= zero_q[k];
				den_q[k+1]  <= den_q[k];
				re_q[k+1]   <= div_step(re_q[k], den_q[k], Q_W - 1 - k);
				im_q[k+1]   <= div_step(im_q[k], den_q[k], Q_W - 1 - k);
			end
		end
	end

	// Finish: saturate both lanes
	assign out_valid = v_q[Q_W];
	assign zero      = zero_q[Q_W];
	assign h_re      = lane_sat(re_q[Q_W], zero_q[Q_W]);
	assign h_im      = lane_sat(im_q[Q_W], zero_q[Q_W]);

endmodule

// ----- rtl/correlation_filter_update.sv -----
// Top level: correlation filter numerator/energy update and per-bin filter output.
//
//  channel    | direction | transaction
//  -----------+-----------+---------------------------------------------------
//  bin_in     | in        | bin_index, f_real, f_imag, g_real, g_imag
//  filt_out   | out       | h_real, h_imag, zero_energy
//  apb        | in        | accumulate @0x0, learn_rate @0x4
//
// One bin per cycle sustained while filt_out is not stalled; a bin's result passes
// through four multiply/add stages, the store write, a 33-stage divider and the
// output register. The per-bin store is read on acceptance and written back
// from stage 4; the last five writes are forwarded so equal bins may follow
// each other. A stall on filt_out freezes the whole pipeline. Reset clears the
// valid bits and the configuration registers; the store itself is not cleared.
`timescale 1ns / 1ps
module correlation_filter_update (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          psel,
	input  logic                          penable,
	input  logic                          pwrite,
	input  logic [cfu_pkg::PADDR_W-1:0]   paddr,
	input  logic [31:0]                   pwdata,
	output logic [31:0]                   prdata,
	output logic                          pready,
	cfu_bin_if.sink                       bin_in,
	cfu_filt_if.source                    filt_out
);
	import cfu_pkg::*;

	// Configuration
	logic              accum_q;
	logic [RATE_W-1:0] rate_q;
	logic              cfg_wr;
	logic [RATE_W-1:0] rate_c;
	logic [RATE_W-1:0] wgt_c;

	// Pipeline control
	logic en;
	logic acc;

	// Stage registers
	logic                     v_s1, v_s2, v_s3, v_s4;
	logic [ADDR_W-1:0]        idx_s1, idx_s2, idx_s3, idx_s4;
	cfu_entry_t               old_s1, old_s2, old_s3, old_s4;
	logic signed [F_W-1:0]    fr_s1, fi_s1;
	logic signed [G_W-1:0]    gr_s1, gi_s1;
	logic signed [F_W+G_W-1:0] p_grfr_s2, p_gifi_s2, p_gifr_s2, p_grfi_s2;
	logic signed [2*F_W-1:0]  p_frfr_s2, p_fifi_s2;
	logic signed [NUM_W-1:0]  nr_s3, ni_s3, nr_s4, ni_s4;
	logic [EN_W-1:0]          e_s3, e_s4;
	logic signed [NUM_W+RATE_W:0] xr_re_s4, xr_im_s4;
	logic [EN_W+RATE_W-1:0]   xe_s4;

	// Store and forwarding history
	cfu_entry_t        mem [NUM_BINS];
	logic              hist_v   [FWD_DEPTH];
	logic [ADDR_W-1:0] hist_idx [FWD_DEPTH];
	cfu_entry_t        hist_d   [FWD_DEPTH];
	cfu_entry_t        old_c;
	cfu_entry_t        blend_c;
	cfu_entry_t        wr_data;
	logic signed [NUM_W+RATE_W+1:0] sum_re, sum_im;
	logic [EN_W+RATE_W+1:0]         sum_e;

	// Divider and output
	logic                  dv_valid;
	logic signed [H_W-1:0] dv_re, dv_im;
	logic                  dv_zero;
	logic                  out_valid_q;
	logic signed [H_W-1:0] h_re_q, h_im_q;
	logic                  zero_q;

	// Register writes
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			accum_q <= 1'b0;
			rate_q  <= RATE_RST;
		end else if (cfg_wr) begin
			if (paddr[2] == REG_ACCUM) begin
				accum_q <= pwdata[0];
			end else begin
				rate_q <= pwdata[RATE_W-1:0];
			end
		end
	end

	// Register reads
	always_comb begin
		if (paddr[2] == REG_RATE) begin
			prdata = 32'(rate_q);
		end else begin
			prdata = 32'(accum_q);
		end
	end

	// Clamp the learning rate to one
	assign rate_c = (rate_q > ONE_Q16) ? ONE_Q16 : rate_q;
	assign wgt_c  = ONE_Q16 - rate_c;

	// Advance everything unless a result waits untaken
	assign en           = !out_valid_q || filt_out.ready;
	assign bin_in.ready = en;
	assign acc          = bin_in.valid && en;

	// Valid pipeline
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else if (en) begin
			v_s1 <= bin_in.valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
		end
	end

	// Store: read on acceptance, write back from stage 4 (read-first)
	always_ff @(posedge clk) begin
		if (acc) begin
			old_s1 <= mem[ADDR_W'(bin_in.bin_index)];
		end
		if (en && v_s4) begin
			mem[idx_s4] <= wr_data;
		end
	end

	// Products, sums, learning-rate products
	always_ff @(posedge clk) begin
		if (en) begin
			idx_s1 <= ADDR_W'(bin_in.bin_index);
			fr_s1  <= bin_in.f_real;
			fi_s1  <= bin_in.f_imag;
			gr_s1  <= bin_in.g_real;
			gi_s1  <= bin_in.g_imag;

			idx_s2    <= idx_s1;
			old_s2    <= old_s1;
			p_grfr_s2 <= gr_s1 * fr_s1;
			p_gifi_s2 <= gi_s1 * fi_s1;
			p_gifr_s2 <= gi_s1 * fr_s1;
			p_grfi_s2 <= gr_s1 * fi_s1;
			p_frfr_s2 <= fr_s1 * fr_s1;
			p_fifi_s2 <= fi_s1 * fi_s1;

			idx_s3 <= idx_s2;
			old_s3 <= old_s2;
			nr_s3  <= NUM_W'(p_grfr_s2) + NUM_W'(p_gifi_s2);
			ni_s3  <= NUM_W'(p_gifr_s2) - NUM_W'(p_grfi_s2);
			e_s3   <= EN_W'(p_frfr_s2[2*F_W-2:0]) + EN_W'(p_fifi_s2[2*F_W-2:0]);

			idx_s4   <= idx_s3;
			old_s4   <= old_s3;
			nr_s4    <= nr_s3;
			ni_s4    <= ni_s3;
			e_s4     <= e_s3;
			xr_re_s4 <= nr_s3 * $signed({1'b0, rate_c});
			xr_im_s4 <= ni_s3 * $signed({1'b0, rate_c});
			xe_s4    <= e_s3 * rate_c;
		end
	end

	// Forward the newest in-flight write to the same bin
	always_comb begin
		old_c = old_s4;
		for (int k = FWD_DEPTH - 1; k >= 0; k--) begin
			if (hist_v[k] && hist_idx[k] == idx_s4) begin
				old_c = hist_d[k];
			end
		end
	end

	// Blend with rounding, then floor by 2^16
	assign sum_re = xr_re_s4 + old_c.nre * $signed({1'b0, wgt_c})
		+ $signed((NUM_W+RATE_W+2)'(32768));
	assign sum_im = xr_im_s4 + old_c.nim * $signed({1'b0, wgt_c})
		+ $signed((NUM_W+RATE_W+2)'(32768));
	assign sum_e  = (EN_W+RATE_W+2)'(xe_s4) + old_c.energy * wgt_c
		+ (EN_W+RATE_W+2)'(32768);

	assign blend_c.nre    = sum_re[FRAC+NUM_W-1:FRAC];
	assign blend_c.nim    = sum_im[FRAC+NUM_W-1:FRAC];
	assign blend_c.energy = sum_e[FRAC+EN_W-1:FRAC];

	assign wr_data = accum_q ? blend_c : cfu_entry_t'({nr_s4, ni_s4, e_s4});

	// Write history: entry 0 also feeds the divider
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < FWD_DEPTH; k++) begin
				hist_v[k] <= 1'b0;
			end
		end else if (en) begin
			hist_v[0] <= v_s4;
			for (int k = 1; k < FWD_DEPTH; k++) begin
				hist_v[k] <= hist_v[k-1];
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			hist_idx[0] <= idx_s4;
			hist_d[0]   <= wr_data;
			for (int k = 1; k < FWD_DEPTH; k++) begin
				hist_idx[k] <= hist_idx[k-1];
				hist_d[k]   <= hist_d[k-1];
			end
		end
	end

	cfu_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (hist_v[0]),
		.num_re    (hist_d[0].nre),
		.num_im    (hist_d[0].nim),
		.den       (hist_d[0].energy),
		.out_valid (dv_valid),
		.h_re      (dv_re),
		.h_im      (dv_im),
		.zero      (dv_zero)
	);

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= dv_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			h_re_q <= dv_re;
			h_im_q <= dv_im;
			zero_q <= dv_zero;
		end
	end

	assign filt_out.valid       = out_valid_q;
	assign filt_out.h_real      = h_re_q;
	assign filt_out.h_imag      = h_im_q;
	assign filt_out.zero_energy = zero_q;

	// Zero energy only ever yields saturated or zero parts
	a_zero_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && zero_q |-> (h_re_q == H_MAX || h_re_q == H_MIN || h_re_q == '0)
			&& (h_im_q == H_MAX || h_im_q == H_MIN || h_im_q == '0))
		else $error("zero-energy result not saturated");

	// No bin accepted while a result waits untaken
	a_no_accept_stall: assert property (@(posedge clk) disable iff (!arst_n)
		bin_in.valid && bin_in.ready |-> !(out_valid_q && !filt_out.ready))
		else $error("bin accepted during output stall");

	// A finished division reaches the output register
	a_div_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		en && dv_valid |=> out_valid_q)
		else $error("divider result lost");

endmodule
